### rtl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants of the stall cycle estimator.
// ----------------------------------------------------------------------------
package scf_pkg;

   // Estimation modes held in the mode register
   localparam logic [1:0] MODE_NOMLP = 2'd0;
   localparam logic [1:0] MODE_CPL   = 2'd1;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_MODE = 2'd1;
   localparam logic [1:0] ST_ZERO_LAT = 2'd2;

   localparam int OVERLAP_FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [47:0] EST_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] OVL_MAX = 32'hFFFF_FFFF;

   // Work class decided at the front
   typedef enum logic [1:0] {
      KIND_BASE  = 2'd0,
      KIND_CPL   = 2'd1,
      KIND_NOMLP = 2'd2,
      KIND_ERR   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] stall;
      logic [31:0] priv;
      logic [31:0] lat_cur;
      logic [31:0] lat_new;
      logic [23:0] reqs;
      logic [23:0] cpl;
   } item_type;

endpackage

### rtl/stall_cycle_estimator_top.sv
// ----------------------------------------------------------------------------
// stall_cycle_estimator_top
// Projects a core's stall cycles under a new average shared-memory latency.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through req_push / req_full; a request is taken on a clock
//   edge with req_push high and req_full low. Results leave through rsp_empty /
//   rsp_pop; the oldest result sits on rsp_* while rsp_empty is low and is
//   consumed on an edge with rsp_pop high.
//   csr_wr_en / csr_wr_data write the estimation mode; write it only while idle.
//   A two-entry queue sits between the classifier and the sequencer, so new
//   requests are taken while a result waits or the sequencer is busy.
//   Path from request to result: in no-overlap mode the sequencer steps through
//   S_DEN, S_CHK, S_DIV (one quotient bit per cycle), S_MUL1-3 and S_FIN; S_DIV
//   is skipped when the overlap saturates before the divide; critical path mode,
//   zero requests and a bad mode go from S_IDLE straight to S_FIN.
//   One sequencer handles one request at a time and takes a new one only once
//   its last result is written.
//   Reset (synchronous) empties the queue and the result register and sets
//   the mode to no-overlap. If rsp_pop stays low the sequencer holds its
//   finished result, the queue fills and req_full rises.
// ----------------------------------------------------------------------------
module stall_cycle_estimator_top #(
   parameter int OVERLAP_FRAC_BITS = scf_pkg::OVERLAP_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_measured_stall_cycles,
   input  logic [31:0] req_private_stall_cycles,
   input  logic [31:0] req_current_latency,
   input  logic [31:0] req_new_latency,
   input  logic [23:0] req_request_count,
   input  logic [23:0] req_critical_path_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [47:0] rsp_stall_estimate,
   output logic [31:0] rsp_overlap_ratio,
   output logic [1:0]  rsp_status
);
   import scf_pkg::*;

   logic     q_valid;
   logic     q_take;
   item_type q_item;

   // Classify and queue requests
   scf_front u_front (
      .clock                     (clock),
      .reset                     (reset),
      .csr_wr_en                 (csr_wr_en),
      .csr_wr_data               (csr_wr_data),
      .req_push                  (req_push),
      .req_full                  (req_full),
      .req_measured_stall_cycles (req_measured_stall_cycles),
      .req_private_stall_cycles  (req_private_stall_cycles),
      .req_current_latency       (req_current_latency),
      .req_new_latency           (req_new_latency),
      .req_request_count         (req_request_count),
      .req_critical_path_length  (req_critical_path_length),
      .q_valid                   (q_valid),
      .q_item                    (q_item),
      .q_take                    (q_take)
   );

   // Compute and hold results
   scf_back #(
      .OVERLAP_FRAC_BITS (OVERLAP_FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_take             (q_take),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_stall_estimate (rsp_stall_estimate),
      .rsp_overlap_ratio  (rsp_overlap_ratio),
      .rsp_status         (rsp_status)
   );

endmodule

### rtl/scf_front.sv
// ----------------------------------------------------------------------------
// scf_front
// Holds the mode register, classifies each request and queues it for the back.
// ----------------------------------------------------------------------------
module scf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   input  logic               req_push,
   output logic               req_full,
   input  logic [31:0]        req_measured_stall_cycles,
   input  logic [31:0]        req_private_stall_cycles,
   input  logic [31:0]        req_current_latency,
   input  logic [31:0]        req_new_latency,
   input  logic [23:0]        req_request_count,
   input  logic [23:0]        req_critical_path_length,
   output logic               q_valid,
   output scf_pkg::item_type  q_item,
   input  logic               q_take
);
   import scf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [1:0]       mode_ff;
   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   item_type         cls_item;
   logic             push_ok;
   logic             pop_ok;

   // Classify the incoming request by mode and zero counts
   always_comb begin
      cls_item.stall   = req_measured_stall_cycles;
      cls_item.priv    = req_private_stall_cycles;
      cls_item.lat_cur = req_current_latency;
      cls_item.lat_new = req_new_latency;
      cls_item.reqs    = req_request_count;
      cls_item.cpl     = req_critical_path_length;
      case (mode_ff)
         MODE_NOMLP: begin
            cls_item.kind = (req_request_count == '0) ? KIND_BASE : KIND_NOMLP;
         end
         MODE_CPL: begin
            cls_item.kind = (req_request_count == '0 || req_critical_path_length == '0)
                            ? KIND_BASE : KIND_CPL;
         end
         default: begin
            cls_item.kind = KIND_ERR;
         end
      endcase
   end

   assign req_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (count_ff != '0);
   assign pop_ok   = q_take && q_valid;
   assign q_item   = entry_ff[rd_ptr_ff];

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NOMLP;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Store classified requests
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= cls_item;
      end
   end

   // Advance queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop_ok)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push_ok && !pop_ok) count_ff <= count_ff + 1'b1;
         else if (pop_ok && !push_ok) count_ff <= count_ff - 1'b1;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      (req_full && !pop_ok) |=> req_full)
      else $error("full queue lost an entry");
`endif

endmodule

### rtl/scf_back.sv
// ----------------------------------------------------------------------------
// scf_back
// Sequencer that divides, multiplies and saturates one request at a time.
// ----------------------------------------------------------------------------
module scf_back #(
   parameter int OVERLAP_FRAC_BITS = scf_pkg::OVERLAP_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  scf_pkg::item_type  q_item,
   output logic               q_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [47:0]        rsp_stall_estimate,
   output logic [31:0]        rsp_overlap_ratio,
   output logic [1:0]         rsp_status
);
   import scf_pkg::*;

   localparam int NUM_SHIFT = 8 + OVERLAP_FRAC_BITS;
   localparam logic [4:0] LAST_STEP = 5'd31;

   typedef enum logic [2:0] {
      S_IDLE, S_DEN, S_CHK, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_FIN
   } state_type;

   state_type   state_ff;
   item_type    item_ff;
   logic [55:0] den_ff;
   logic [55:0] rem_ff;
   logic [31:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] ovl_ff;
   logic [1:0]  status_ff;
   logic [63:0] prod_ff;
   logic [87:0] acc_ff;
   logic        res_valid_ff;
   logic [47:0] est_ff;
   logic [31:0] ovl_out_ff;
   logic [1:0]  status_out_ff;

   logic [63:0] num_c;
   logic [56:0] trial;
   logic [56:0] diff;
   logic        ge;
   logic [87:0] add_val;
   logic [88:0] sum;
   logic [47:0] est_c;
   logic        res_free;

   assign q_take             = (state_ff == S_IDLE) && q_valid;
   assign rsp_empty          = !res_valid_ff;
   assign rsp_stall_estimate = est_ff;
   assign rsp_overlap_ratio  = ovl_out_ff;
   assign rsp_status         = status_out_ff;
   assign res_free           = !res_valid_ff || rsp_pop;

   // Scaled dividend and one restoring division step
   always_comb begin
      num_c = 64'(item_ff.stall) << NUM_SHIFT;
      trial = {rem_ff, quo_ff[31]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
   end

   // Final add of the private part with saturation
   always_comb begin
      add_val = (item_ff.kind == KIND_CPL) ? acc_ff : (acc_ff >> OVERLAP_FRAC_BITS);
      sum     = 89'({item_ff.priv, 8'b0}) + 89'(add_val);
      est_c   = (sum > 89'(EST_MAX)) ? EST_MAX : sum[47:0];
   end

   // Sequence one request through the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         // Drop a popped result unless a new one replaces it this cycle
         if (rsp_pop && res_valid_ff && state_ff != S_FIN) res_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff   <= q_item;
                  status_ff <= ST_OK;
                  ovl_ff    <= '0;
                  case (q_item.kind)
                     KIND_NOMLP: begin
                        acc_ff   <= '0;
                        state_ff <= S_DEN;
                     end
                     KIND_CPL: begin
                        acc_ff   <= 88'(56'(q_item.cpl) * 56'(q_item.lat_new));
                        state_ff <= S_FIN;
                     end
                     default: begin
                        acc_ff   <= '0;
                        state_ff <= S_FIN;
                     end
                  endcase
               end
            end
            S_DEN: begin
               den_ff   <= 56'(item_ff.lat_cur) * 56'(item_ff.reqs);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (den_ff == '0) begin
                  ovl_ff    <= OVL_MAX;
                  status_ff <= ST_ZERO_LAT;
                  state_ff  <= S_MUL1;
               end else if (56'(num_c[63:32]) >= den_ff) begin
                  ovl_ff   <= OVL_MAX;
                  state_ff <= S_MUL1;
               end else begin
                  rem_ff   <= 56'(num_c[63:32]);
                  quo_ff   <= num_c[31:0];
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= ge ? diff[55:0] : trial[55:0];
               quo_ff <= {quo_ff[30:0], ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_STEP) begin
                  ovl_ff   <= {quo_ff[30:0], ge};
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               prod_ff  <= 64'(ovl_ff) * 64'(item_ff.lat_new);
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               acc_ff   <= 88'(56'(prod_ff[31:0]) * 56'(item_ff.reqs));
               state_ff <= S_MUL3;
            end
            S_MUL3: begin
               acc_ff   <= acc_ff + (88'(56'(prod_ff[63:32]) * 56'(item_ff.reqs)) << 32);
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (res_free) begin
                  res_valid_ff <= 1'b1;
                  if (item_ff.kind == KIND_ERR) begin
                     est_ff        <= '0;
                     ovl_out_ff    <= '0;
                     status_out_ff <= ST_BAD_MODE;
                  end else begin
                     est_ff        <= est_c;
                     ovl_out_ff    <= ovl_ff;
                     status_out_ff <= status_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_zero_lat_sat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_ZERO_LAT) |-> (rsp_overlap_ratio == OVL_MAX))
      else $error("zero latency without saturated overlap");
   a_bad_mode_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_BAD_MODE)
      |-> (rsp_stall_estimate == '0 && rsp_overlap_ratio == '0))
      else $error("bad mode result not cleared");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (den_ff != '0))
      else $error("division by zero divisor");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |=> (state_ff != S_IDLE))
      else $error("request taken but sequencer idle");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the stall cycle estimator against an in-bench predictor. Requests
// are pushed with random gaps and results popped with random stalls. Each
// result is compared field by field with the oldest predicted estimate, over
// all estimation modes, directed corner requests and random requests.
// ----------------------------------------------------------------------------
module tb_top;
   import scf_pkg::*;

   localparam int FRAC = OVERLAP_FRAC_BITS_DEF;
   localparam logic [1:0] MODE_BAD2 = 2'd2;
   localparam logic [1:0] MODE_BAD3 = 2'd3;

   typedef struct {
      logic [47:0] est;
      logic [31:0] ovl;
      logic [1:0]  status;
   } estimate_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_measured_stall_cycles = '0;
   logic [31:0] req_private_stall_cycles = '0;
   logic [31:0] req_current_latency = '0;
   logic [31:0] req_new_latency = '0;
   logic [23:0] req_request_count = '0;
   logic [23:0] req_critical_path_length = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [47:0] rsp_stall_estimate;
   logic [31:0] rsp_overlap_ratio;
   logic [1:0]  rsp_status;

   logic [1:0]   cur_mode = MODE_NOMLP;
   estimate_type pending_estimates[$];
   int           error_count = 0;
   bit           pop_gaps = 1'b1;
   bit           push_gaps = 1'b1;

   stall_cycle_estimator_top i_dut (.*);

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predict one estimate from the current mode
   function automatic estimate_type predict_estimate(logic [31:0] stall, logic [31:0] priv,
         logic [31:0] lat_cur, logic [31:0] lat_new, logic [23:0] reqs, logic [23:0] cpl);
      estimate_type r;
      logic [63:0]  den;
      logic [63:0]  quo;
      logic [127:0] prod;
      logic [127:0] shared;
      logic [127:0] sum;
      r.est = '0;
      r.ovl = '0;
      r.status = ST_OK;
      sum = {88'd0, priv, 8'd0};
      if (cur_mode == MODE_NOMLP) begin
         if (reqs == 0) begin
            r.est = sum[47:0];
         end else begin
            den = 64'(lat_cur) * 64'(reqs);
            if (den == 0) begin
               r.ovl = OVL_MAX;
               r.status = ST_ZERO_LAT;
            end else begin
               quo = (64'(stall) << (8 + FRAC)) / den;
               r.ovl = (quo > 64'(OVL_MAX)) ? OVL_MAX : quo[31:0];
            end
            prod = 128'(r.ovl) * 128'(lat_new) * 128'(reqs);
            shared = prod >> FRAC;
            sum = sum + shared;
            r.est = (sum > 128'(EST_MAX)) ? EST_MAX : sum[47:0];
         end
      end else if (cur_mode == MODE_CPL) begin
         if (reqs != 0 && cpl != 0) sum = sum + 128'(cpl) * 128'(lat_new);
         r.est = (sum > 128'(EST_MAX)) ? EST_MAX : sum[47:0];
      end else begin
         r.status = ST_BAD_MODE;
      end
      return r;
   endfunction

   // append one prediction at the tail of the scoreboard
   task automatic add_prediction(estimate_type e);
      pending_estimates = {pending_estimates, e};
   endtask

   // send one request and queue its prediction; push stays high for a follower
   task automatic send_request(logic [31:0] stall, logic [31:0] priv, logic [31:0] lat_cur,
         logic [31:0] lat_new, logic [23:0] reqs, logic [23:0] cpl);
      int gap;
      gap = push_gaps ? $urandom_range(0, 15) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_measured_stall_cycles <= stall;
      req_private_stall_cycles <= priv;
      req_current_latency <= lat_cur;
      req_new_latency <= lat_new;
      req_request_count <= reqs;
      req_critical_path_length <= cpl;
      @(posedge clock);
      while (req_full) @(posedge clock);
      add_prediction(predict_estimate(stall, priv, lat_cur, lat_new, reqs, cpl));
   endtask

   // wait for drain, then write the mode
   task automatic write_mode(logic [1:0] mode);
      req_push <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = mode;
   endtask

   // random field with a bias toward edges
   function automatic logic [31:0] rand_word(int width);
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = 0;
         1: v = '1;
         2: v = $urandom_range(0, 255);
         3: v = $urandom_range(0, 65535);
         default: v = $urandom;
      endcase
      return 32'(64'(v) & ((64'd1 << width) - 64'd1));
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         send_request(rand_word(32), rand_word(32), rand_word(32), rand_word(32),
            24'(rand_word(24)), 24'(rand_word(24)));
      end
   endtask

   task automatic test_directed_nomlp();
      write_mode(MODE_NOMLP);
      send_request(32'd0, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
      send_request('1, '1, '1, '1, 24'd0, '1);
      send_request(32'd1000, 32'd50, 32'h100, 32'h200, 24'd10, 24'd3);
      send_request(32'd1000, 32'd50, 32'd0, 32'h200, 24'd10, 24'd3);
      send_request(32'd0, 32'd7, 32'd0, 32'h300, 24'd1, 24'd0);
      send_request('1, '1, 32'd1, '1, '1, '1);
      send_request('1, '1, '1, '1, '1, '1);
      send_request(32'd1, 32'd0, '1, 32'd1, 24'd1, 24'd1);
      send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
         24'hAAAAAA, 24'h555555);
   endtask

   task automatic test_directed_cpl();
      write_mode(MODE_CPL);
      send_request(32'd5, 32'd9, 32'h100, 32'h180, 24'd0, 24'd4);
      send_request(32'd5, 32'd9, 32'h100, 32'h180, 24'd4, 24'd0);
      send_request(32'd5, 32'd9, 32'h100, 32'h180, 24'd4, 24'd6);
      send_request('1, '1, '1, '1, '1, '1);
      send_request(32'd0, 32'd0, 32'd0, 32'd0, 24'd1, 24'd1);
   endtask

   task automatic test_bad_modes();
      write_mode(MODE_BAD2);
      send_request('1, '1, '1, '1, '1, '1);
      send_random(20);
      write_mode(MODE_BAD3);
      send_request(32'd1, 32'd2, 32'd3, 32'd4, 24'd5, 24'd6);
      send_random(20);
   endtask

   task automatic test_random_modes();
      write_mode(MODE_NOMLP);
      send_random(700);
      write_mode(MODE_CPL);
      send_random(500);
      // back-to-back burst without idling
      push_gaps = 1'b0;
      pop_gaps = 1'b0;
      write_mode(MODE_NOMLP);
      send_random(150);
      push_gaps = 1'b1;
      pop_gaps = 1'b1;
      write_mode(MODE_CPL);
      send_random(140);
   endtask

   // pop results with random stalls; hold pop until a result is taken
   initial begin
      int stall_len;
      forever begin
         stall_len = pop_gaps ? $urandom_range(0, 15) : 0;
         if ($urandom_range(0, 3) == 0) stall_len = 0;
         if (stall_len != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (reset || rsp_empty) @(posedge clock);
      end
   end

   // check each popped result against the oldest prediction
   always @(posedge clock) begin
      estimate_type exp_est;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_estimates.size() == 0) begin
            $error("result with no request outstanding");
            error_count++;
         end else begin
            exp_est = pending_estimates.pop_front();
            if (rsp_stall_estimate !== exp_est.est) begin
               $error("stall_estimate: expected %h actual %h", exp_est.est,
                  rsp_stall_estimate);
               error_count++;
            end
            if (rsp_overlap_ratio !== exp_est.ovl) begin
               $error("overlap_ratio: expected %h actual %h", exp_est.ovl, rsp_overlap_ratio);
               error_count++;
            end
            if (rsp_status !== exp_est.status) begin
               $error("status: expected %0d actual %0d", exp_est.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_nomlp();
      test_directed_cpl();
      test_bad_modes();
      test_random_modes();
      req_push <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_estimates.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("tb_top failed");
      $finish;
   end

endmodule
